FILE: rtl/dcae_pkg.sv
package dcae_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_OPTION_BITS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_LENGTH = 1'b1;

   // option bit positions
   localparam int OPT_STOP_NONALNUM = 0;
   localparam int OPT_STOP_SPACE    = 1;
   localparam int OPT_STOP_ZERO     = 2;
   localparam int OPT_SKIP_EOL      = 3;

   // display codes of note
   localparam logic [5:0] CODE_ZERO       = 6'd0;
   localparam logic [5:0] CODE_SPACE      = 6'o55;
   localparam logic [5:0] CODE_ALNUM_MAX  = 6'd36;

   // ascii codes of note
   localparam logic [6:0] ASCII_NUL   = 7'h00;
   localparam logic [6:0] ASCII_SPACE = 7'h20;
   localparam logic [6:0] ASCII_COLON = 7'h3a;

   // display code map
   localparam logic [6:0] DC_TABLE [64] = '{
      7'h3a, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
      7'h48, 7'h49, 7'h4a, 7'h4b, 7'h4c, 7'h4d, 7'h4e, 7'h4f,
      7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57,
      7'h58, 7'h59, 7'h5a, 7'h30, 7'h31, 7'h32, 7'h33, 7'h34,
      7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h2b, 7'h2d, 7'h2a,
      7'h2f, 7'h28, 7'h29, 7'h24, 7'h3d, 7'h20, 7'h2c, 7'h2e,
      7'h23, 7'h5b, 7'h5d, 7'h25, 7'h22, 7'h5f, 7'h21, 7'h26,
      7'h27, 7'h3f, 7'h3c, 7'h3e, 7'h40, 7'h5c, 7'h5e, 7'h3b
   };

   typedef struct packed {
      logic [6:0] ascii;
      logic       record_end;
   } beat_type;

   localparam beat_type TERM_BEAT  = '{ascii: ASCII_NUL,   record_end: 1'b1};
   localparam beat_type SPACE_BEAT = '{ascii: ASCII_SPACE, record_end: 1'b0};
   localparam beat_type NULL_BEAT  = '{ascii: ASCII_NUL,   record_end: 1'b0};

   // results of one item: a run of colons, then up to two tail beats
   typedef struct packed {
      logic [3:0] colons;
      logic [1:0] tail_cnt;
      beat_type   tail0;
      beat_type   tail1;
   } desc_type;

   typedef struct packed {
      logic [3:0]  word_slot;
      logic [15:0] char_count;
      logic [3:0]  zero_run;
      logic        run_spans_next_word;
      logic        halted;
   } state_type;

endpackage

FILE: rtl/dcae_step.sv
module dcae_step #(
   parameter int WORD_CHARS = 10
) (
   input  logic [5:0]           code,
   input  dcae_pkg::state_type  state,
   input  logic [3:0]           option_bits,
   input  logic [15:0]          record_length,
   output dcae_pkg::state_type  next_state,
   output dcae_pkg::desc_type   desc
);
   import dcae_pkg::*;

   localparam logic [4:0] WordChars = 5'(WORD_CHARS);

   logic [16:0] consumed;
   logic        last;
   logic        spaces_fit;
   logic [4:0]  slot_inc;
   logic        slot_end;
   logic        zero_item;
   logic        code_stop;
   logic [3:0]  run_inc;
   logic        eol;

   assign consumed   = {1'b0, state.char_count} + 17'd1;
   assign last       = consumed >= {1'b0, record_length};
   assign spaces_fit = ({1'b0, consumed} + 18'd2) < {2'b00, record_length};
   assign slot_inc   = {1'b0, state.word_slot} + 5'd1;
   assign slot_end   = slot_inc >= WordChars;
   assign zero_item  = (code == CODE_ZERO) && option_bits[OPT_SKIP_EOL];
   assign run_inc    = state.zero_run + 4'd1;
   assign code_stop  = (option_bits[OPT_STOP_NONALNUM] && (code > CODE_ALNUM_MAX)) ||
                       (option_bits[OPT_STOP_SPACE] && (code == CODE_SPACE)) ||
                       (option_bits[OPT_STOP_ZERO] && (code == CODE_ZERO));

   always_comb begin
      next_state    = state;
      desc.colons   = 4'd0;
      desc.tail_cnt = 2'd0;
      desc.tail0    = NULL_BEAT;
      desc.tail1    = NULL_BEAT;
      eol           = 1'b0;
      if (!state.halted) begin
         if (zero_item) begin
            // hold the zero until the line end is known
            next_state.zero_run = run_inc;
            eol = last;
            if (slot_end) begin
               if (state.run_spans_next_word || (run_inc > 4'd1)) begin
                  eol = 1'b1;
               end else begin
                  next_state.run_spans_next_word = 1'b1;
               end
            end
            if (eol) begin
               next_state.zero_run            = 4'd0;
               next_state.run_spans_next_word = 1'b0;
               if (spaces_fit) begin
                  desc.tail0    = SPACE_BEAT;
                  desc.tail1    = SPACE_BEAT;
                  desc.tail_cnt = 2'd2;
               end else if (last) begin
                  desc.tail0    = TERM_BEAT;
                  desc.tail_cnt = 2'd1;
               end
            end
         end else begin
            next_state.zero_run            = 4'd0;
            next_state.run_spans_next_word = 1'b0;
            if ((state.zero_run != 4'd0) && option_bits[OPT_STOP_ZERO]) begin
               // stop at the first held zero
               next_state.halted = 1'b1;
               desc.tail0        = TERM_BEAT;
               desc.tail_cnt     = 2'd1;
            end else begin
               desc.colons = state.zero_run;
               if (code_stop) begin
                  next_state.halted = 1'b1;
                  desc.tail0        = TERM_BEAT;
                  desc.tail_cnt     = 2'd1;
               end else begin
                  desc.tail0 = '{ascii: DC_TABLE[code], record_end: 1'b0};
                  if (last) begin
                     desc.tail1    = TERM_BEAT;
                     desc.tail_cnt = 2'd2;
                  end else begin
                     desc.tail_cnt = 2'd1;
                  end
               end
            end
         end
      end
      if (last) begin
         next_state = '0;
      end else begin
         next_state.char_count = consumed[15:0];
         next_state.word_slot  = slot_end ? 4'd0 : slot_inc[3:0];
      end
   end

endmodule

FILE: rtl/dcae_emit.sv
module dcae_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  dcae_pkg::desc_type  desc,
   input  logic                rsp_stall,
   output logic                free,
   output logic                rsp_valid,
   output logic [6:0]          rsp_ascii,
   output logic                rsp_record_end
);
   import dcae_pkg::*;

   logic [3:0] colons_ff, colons_in;
   logic [1:0] tail_left_ff, tail_left_in;
   beat_type   tail0_ff, tail0_in;
   beat_type   tail1_ff, tail1_in;
   logic       last_beat;
   logic       take;

   assign rsp_valid = (colons_ff != 4'd0) || (tail_left_ff != 2'd0);
   assign last_beat = ((colons_ff == 4'd0) && (tail_left_ff == 2'd1)) ||
                      ((colons_ff == 4'd1) && (tail_left_ff == 2'd0));
   assign take      = rsp_valid && !rsp_stall;
   assign free      = !rsp_valid || (last_beat && !rsp_stall);

   assign rsp_ascii      = (colons_ff != 4'd0) ? ASCII_COLON : tail0_ff.ascii;
   assign rsp_record_end = (colons_ff != 4'd0) ? 1'b0 : tail0_ff.record_end;

   always_comb begin
      colons_in    = colons_ff;
      tail_left_in = tail_left_ff;
      tail0_in     = tail0_ff;
      tail1_in     = tail1_ff;
      if (load) begin
         colons_in    = desc.colons;
         tail_left_in = desc.tail_cnt;
         tail0_in     = desc.tail0;
         tail1_in     = desc.tail1;
      end else if (take) begin
         if (colons_ff != 4'd0) begin
            colons_in = colons_ff - 4'd1;
         end else begin
            tail0_in     = tail1_ff;
            tail_left_in = tail_left_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colons_ff    <= 4'd0;
         tail_left_ff <= 2'd0;
      end else begin
         colons_ff    <= colons_in;
         tail_left_ff <= tail_left_in;
      end
      tail0_ff <= tail0_in;
      tail1_ff <= tail1_in;
   end

endmodule

FILE: rtl/display_code_to_ascii_eol.sv
// Display-code to ASCII converter with end-of-line skipping. Each accepted
// beat on req_ carries one 6-bit display code of a record; rsp_ returns the
// ASCII text, closed by a zero terminator beat with rsp_record_end high.
// csr index 0 holds the option bits (stop on non-alphanumeric, stop on space,
// stop on zero, skip end of line), index 1 the record length; write them only
// while the block is idle. The block takes one code per cycle as long as each
// code yields at most one result beat and rsp_stall stays low. A code that
// yields more than one beat (released colons, two spaces, a character plus the
// terminator) holds the output serializer until its last beat is taken,
// and the input register waits behind it; codes that yield nothing never
// wait. Throughput is set by the output serializer, one beat per unstalled cycle.
module display_code_to_ascii_eol #(
   parameter int WORD_CHARS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [5:0]                     req_code,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [6:0]                     rsp_ascii,
   output logic                           rsp_record_end,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dcae_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                    csr_wdata
);
   import dcae_pkg::*;

   // configuration registers
   logic [3:0]  option_bits_ff, option_bits_in;
   logic [15:0] record_length_ff, record_length_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [5:0]  code_ff, code_in;

   // record state
   state_type   state_ff, state_in;

   desc_type    desc;
   logic        beats_zero;
   logic        free;
   logic        advance;
   logic        req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      option_bits_in   = option_bits_ff;
      record_length_in = record_length_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OPTION_BITS:   option_bits_in   = csr_wdata[3:0];
            CSR_RECORD_LENGTH: record_length_in = csr_wdata;
            default: ;
         endcase
      end
   end

   dcae_step #(
      .WORD_CHARS(WORD_CHARS)
   ) u_step (
      .code          (code_ff),
      .state         (state_ff),
      .option_bits   (option_bits_ff),
      .record_length (record_length_ff),
      .next_state    (state_in),
      .desc          (desc)
   );

   // an item with no results retires without touching the serializer
   assign beats_zero = (desc.colons == 4'd0) && (desc.tail_cnt == 2'd0);
   assign advance    = in_valid_ff && (beats_zero || free);
   assign req_stall  = in_valid_ff && !advance;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      code_in     = code_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         code_in     = req_code;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   dcae_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && !beats_zero),
      .desc           (desc),
      .rsp_stall      (rsp_stall),
      .free           (free),
      .rsp_valid      (rsp_valid),
      .rsp_ascii      (rsp_ascii),
      .rsp_record_end (rsp_record_end)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         option_bits_ff   <= 4'd0;
         record_length_ff <= 16'd1;
         in_valid_ff      <= 1'b0;
         state_ff         <= '0;
      end else begin
         option_bits_ff   <= option_bits_in;
         record_length_ff <= record_length_in;
         in_valid_ff      <= in_valid_in;
         // record state moves only when an item retires
         if (advance) begin
            state_ff <= state_in;
         end
      end
      code_ff <= code_in;
   end

endmodule

FILE: rtl/dcae_checker.sv
module dcae_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [5:0]                     req_code,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [6:0]                     rsp_ascii,
   input logic                           rsp_record_end,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [dcae_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [15:0]                    csr_wdata
);
   import dcae_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ascii) &&
      $stable(rsp_record_end))
      else $error("stalled result beat changed");

   // the terminator carries a zero character
   a_term_nul: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_end |-> rsp_ascii == ASCII_NUL)
      else $error("terminator beat with nonzero character");

   // a zero character appears only on the terminator
   a_nul_term: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ascii == ASCII_NUL |-> rsp_record_end)
      else $error("zero character outside the terminator");

   // reset empties the output side
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind display_code_to_ascii_eol dcae_checker u_checker (.*);

FILE: bench/display_code_to_ascii_eol_tb.sv
`timescale 1ns / 100ps

module display_code_to_ascii_eol_tb;
   import dcae_pkg::*;

   localparam int WORD_CHARS = 10;
   localparam int MAX_WAIT   = 17;
   localparam int DRAIN_CYCLES = 20;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [5:0]           req_code;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [6:0]           rsp_ascii;
   logic                 rsp_record_end;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;

   display_code_to_ascii_eol #(.WORD_CHARS(WORD_CHARS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code       (req_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii      (rsp_ascii),
      .rsp_record_end (rsp_record_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // display code to ascii, indexed by code
   string dc_map = ":ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+-*/()$= ,.#[]%\"_!&'?<>@\\^;";

   // shadow of the converter: registers and record state
   logic [3:0]  opt_bits;
   logic [15:0] rec_len;
   logic [3:0]  slot_pos;
   logic [15:0] chars_seen;
   logic [3:0]  held_zeros;
   logic        held_spans;
   logic        text_halted;

   // beats still owed by the converter, oldest first
   beat_type expected_beats[$];
   beat_type next_beat;

   // codes waiting to be driven
   logic [5:0] code_q[$];
   int items_queued;
   int items_taken;
   int fail_count;

   // handshake results seen at the last rising edge
   logic req_taken;
   logic rsp_taken;

   // idle control for each side
   int req_gap;
   int rsp_hold;
   logic req_burst;
   logic rsp_burst;

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // output stops: stop the text, emit the terminator now
   task automatic halt_text();
      text_halted = 1'b1;
      held_zeros  = 4'd0;
      held_spans  = 1'b0;
      expected_beats.push_back(TERM_BEAT);
   endtask

   // work out the beats that one accepted code produces
   task automatic predict_ascii(input logic [5:0] code);
      int used;
      logic last;
      logic eol;
      used = int'(chars_seen) + 1;
      last = used >= int'(rec_len);
      if (!text_halted) begin
         if (code == CODE_ZERO && opt_bits[OPT_SKIP_EOL]) begin
            // zero held back until we know if it ends the line
            eol = last;
            held_zeros = held_zeros + 4'd1;
            if (int'(slot_pos) + 1 >= WORD_CHARS) begin
               // last slot: a run reaching here ends the line, a lone zero
               // has to wait for a fully zero next word
               if (held_spans || held_zeros > 4'd1) begin
                  eol = 1'b1;
               end else begin
                  held_spans = 1'b1;
               end
            end
            if (eol) begin
               held_zeros = 4'd0;
               held_spans = 1'b0;
               if (used + 2 < int'(rec_len)) begin
                  expected_beats.push_back(SPACE_BEAT);
                  expected_beats.push_back(SPACE_BEAT);
               end
            end
         end else begin
            // held zeros were not end of line: release as colons or stop
            while (held_zeros > 4'd0 && !text_halted) begin
               if (opt_bits[OPT_STOP_ZERO]) begin
                  halt_text();
               end else begin
                  expected_beats.push_back('{ascii: ASCII_COLON, record_end: 1'b0});
                  held_zeros = held_zeros - 4'd1;
               end
            end
            held_spans = 1'b0;
            if (!text_halted) begin
               if ((opt_bits[OPT_STOP_NONALNUM] && code > CODE_ALNUM_MAX) ||
                   (opt_bits[OPT_STOP_SPACE] && code == CODE_SPACE) ||
                   (opt_bits[OPT_STOP_ZERO] && code == CODE_ZERO)) begin
                  halt_text();
               end else begin
                  expected_beats.push_back('{ascii: 7'(dc_map[code]), record_end: 1'b0});
               end
            end
         end
         if (last && !text_halted) begin
            expected_beats.push_back(TERM_BEAT);
         end
      end
      // record end clears everything, otherwise step through the word
      if (last) begin
         slot_pos    = 4'd0;
         chars_seen  = 16'd0;
         held_zeros  = 4'd0;
         held_spans  = 1'b0;
         text_halted = 1'b0;
      end else begin
         chars_seen = 16'(used);
         slot_pos   = (int'(slot_pos) + 1 >= WORD_CHARS) ? 4'd0 : slot_pos + 4'd1;
      end
   endtask

   // monitor: check result beats, then feed the predictor
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
         rsp_taken = 1'b0;
      end else begin
         rsp_taken = rsp_valid && !rsp_stall;
         req_taken = req_valid && !req_stall;
         if (rsp_taken) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected beat: ascii %h record_end %b", rsp_ascii, rsp_record_end);
               fail_count++;
            end else begin
               next_beat = expected_beats.pop_front();
               if (rsp_ascii !== next_beat.ascii) begin
                  $error("ascii: expected %h, got %h", next_beat.ascii, rsp_ascii);
                  fail_count++;
               end
               if (rsp_record_end !== next_beat.record_end) begin
                  $error("record_end: expected %b, got %b",
                         next_beat.record_end, rsp_record_end);
                  fail_count++;
               end
            end
         end
         // register writes only land while the converter is idle
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OPTION_BITS: begin
                  opt_bits = csr_wdata[3:0];
               end
               CSR_RECORD_LENGTH: begin
                  rec_len = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_taken) begin
            predict_ascii(req_code);
            items_taken++;
         end
      end
   end

   // code driver: one beat per code, random gap after each accepted beat
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_taken) begin
            // flip between bursts with no gaps and gappy stretches
            if ($urandom_range(0, 15) == 0) begin
               req_burst = !req_burst;
            end
            req_gap = req_burst ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (req_valid && !req_taken) begin
            // stalled beat holds its code
         end else if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (code_q.size() != 0) begin
            req_valid <= 1'b1;
            req_code  <= code_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: stall for a random count after each accepted beat
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 15) == 0) begin
               rsp_burst = !rsp_burst;
            end
            rsp_hold = rsp_burst ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // single register write on the csr channel
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_code(input logic [5:0] code);
      code_q.push_back(code);
      items_queued++;
   endtask

   // random text: zero runs, spaces and the alphanumeric boundary favored
   task automatic queue_text(input int count);
      int zeros_left;
      int k;
      zeros_left = 0;
      for (k = 0; k < count; k++) begin
         if (zeros_left > 0) begin
            queue_code(CODE_ZERO);
            zeros_left--;
         end else begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  queue_code(CODE_ZERO);
                  zeros_left = $urandom_range(0, 13);
               end
               2: begin
                  queue_code(CODE_SPACE);
               end
               3: begin
                  queue_code($urandom_range(0, 1) ? CODE_ALNUM_MAX : CODE_ALNUM_MAX + 6'd1);
               end
               default: begin
                  queue_code(6'($urandom_range(0, 63)));
               end
            endcase
         end
      end
   endtask

   // wait until every code is in and every beat is out, then let the
   // pipeline settle in case the last codes were held zeros
   task automatic settle();
      while (items_taken != items_queued || expected_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int random_items;
      int count;
      logic [3:0] opt;
      logic [15:0] len;

      // every input known from time zero
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_code     = 6'd0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_OPTION_BITS;
      csr_wdata    = 16'd0;
      opt_bits     = 4'd0;
      rec_len      = 16'd1;
      slot_pos     = 4'd0;
      chars_seen   = 16'd0;
      held_zeros   = 4'd0;
      held_spans   = 1'b0;
      text_halted  = 1'b0;
      items_queued = 0;
      items_taken  = 0;
      fail_count   = 0;
      req_taken    = 1'b0;
      rsp_taken    = 1'b0;
      req_gap      = 0;
      rsp_hold     = 0;
      req_burst    = 1'b0;
      rsp_burst    = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // plain mapping: zero becomes a colon, top code, last alphanumeric
      csr_write(CSR_OPTION_BITS, 16'd0);
      csr_write(CSR_RECORD_LENGTH, 16'd3);
      queue_code(CODE_ZERO);
      queue_code(6'd63);
      queue_code(CODE_ALNUM_MAX);
      settle();

      // end of line skipping: run to end of word with spaces, then a run
      // cut short by the record end
      csr_write(CSR_OPTION_BITS, 16'd8);
      csr_write(CSR_RECORD_LENGTH, 16'd14);
      queue_code(6'd1);
      queue_code(6'd2);
      queue_code(CODE_ZERO);
      queue_code(CODE_ZERO);
      queue_code(6'd5);
      queue_code(6'd6);
      queue_code(6'd7);
      queue_code(6'd8);
      queue_code(CODE_ZERO);
      queue_code(CODE_ZERO);
      queue_code(6'd3);
      queue_code(CODE_ZERO);
      queue_code(CODE_ZERO);
      queue_code(CODE_ZERO);
      settle();

      // all options: held zero then a letter stops output, rest swallowed
      csr_write(CSR_OPTION_BITS, 16'd15);
      csr_write(CSR_RECORD_LENGTH, 16'd4);
      queue_code(CODE_ZERO);
      queue_code(6'd9);
      queue_code(6'd3);
      queue_code(6'd4);
      settle();

      // stop on space
      csr_write(CSR_OPTION_BITS, 16'd2);
      csr_write(CSR_RECORD_LENGTH, 16'd3);
      queue_code(CODE_SPACE);
      queue_code(6'd1);
      queue_code(6'd2);
      settle();

      // longest record, left open with zeros held; next phase rewrites the length
      csr_write(CSR_OPTION_BITS, 16'd8);
      csr_write(CSR_RECORD_LENGTH, 16'hFFFF);
      queue_code(6'd1);
      queue_code(CODE_ZERO);
      queue_code(CODE_ZERO);
      settle();

      // random phases, each with fresh options and record length
      random_items = 0;
      while (random_items < 130) begin
         opt = 4'($urandom_range(0, 15));
         case ($urandom_range(0, 9))
            0: begin
               len = 16'($urandom_range(0, 2));
            end
            1: begin
               len = 16'hFFFF;
            end
            2: begin
               len = 16'($urandom_range(30, 80));
            end
            default: begin
               len = 16'($urandom_range(3, 30));
            end
         endcase
         if (len > 16'd0 && len <= 16'd40) begin
            count = int'(len) * $urandom_range(1, 2);
         end else begin
            count = $urandom_range(5, 30);
         end
         csr_write(CSR_OPTION_BITS, {12'd0, opt});
         csr_write(CSR_RECORD_LENGTH, len);
         queue_text(count);
         random_items += count;
         settle();
      end

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // hard limit well above the slowest legal run
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/dcae_pkg.sv
rtl/dcae_step.sv
rtl/dcae_emit.sv
rtl/display_code_to_ascii_eol.sv
rtl/dcae_checker.sv
bench/display_code_to_ascii_eol_tb.sv
